FILE: sv/pixel_gradient_edge_detect_defines.svh
// assertion macros for the pixel gradient edge detector
// used by modules that assert; expects clk and arst_n in scope
`ifndef PIXEL_GRADIENT_EDGE_DETECT_DEFINES_SVH
`define PIXEL_GRADIENT_EDGE_DETECT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PGE_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define PGE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define PGE_ASSERT(lbl, cond, msg)
`define PGE_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: sv/pge_pkg.sv
// shared types and constants of the pixel gradient edge detector
// no dependencies
package pge_pkg;
	localparam int LINE_WIDTH_DEF = 4096;
	localparam int QUEUE_DEPTH = 4;

	// register indexes
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [2:0] REG_GAIN         = 3'd2;
	localparam logic [2:0] REG_CHROMA_MODE  = 3'd3;
	localparam logic [2:0] REG_ALPHA_ON     = 3'd4;

	localparam logic [12:0] WIDTH_RST  = 13'd640;
	localparam logic [12:0] HEIGHT_RST = 13'd480;
	localparam logic [7:0]  GAIN_RST   = 8'd1;

	localparam logic [15:0] MAX_FRAME_HEIGHT = 16'd4096;
	localparam logic [7:0]  CHROMA_BIAS = 8'h80;
	localparam logic [7:0]  EDGE_MAX = 8'hff;

	typedef struct packed {
		logic [12:0] frame_width;
		logic [12:0] frame_height;
		logic [7:0]  gain;
		logic        chroma_mode;
		logic        alpha_on;
	} cfg_t;

	typedef struct packed {
		logic [11:0] row;
		logic [11:0] col;
		logic [31:0] p00;
		logic [31:0] p01;
		logic [31:0] p10;
		logic [31:0] p11;
		logic        last;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;
endpackage

FILE: sv/pixel_gradient_edge_detect.sv
// top level of the 2x2 gradient magnitude edge detector
// depends on pge_pkg, pge_front, pge_queue, pge_back
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  pixel: ch0, ch1, ch2, alpha
// m_*       out  m_tvalid/m_tready  row, col, edges, alpha; tlast ends a run
// apb       in   psel/penable       five config registers at 4*i
//
// front end takes a new pixel only after it has read the line store and issued every job of the last one
// back end finishes one result before it takes the next job, through square, gain and the 8-step square root unit
// a four-entry job queue lets front and back stall independently
// arst_n clears counters, state and config; line store is not cleared
// a stalled result holds in the output register while new pixels still enter until the job queue fills
module pixel_gradient_edge_detect import pge_pkg::*; #(
	parameter int MAX_LINE_WIDTH = LINE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // chan_zero, chan_one, chan_two, alpha_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // out_row, out_col, edge_zero, edge_one, edge_two, alpha_out
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t    cfg_q;
	q_stat_t q_stat;
	job_t    push_job, pop_job;
	logic    push, pop;
	logic [2:0] reg_idx;

	// register file, written in the access phase
	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= WIDTH_RST;
			cfg_q.frame_height <= HEIGHT_RST;
			cfg_q.gain <= GAIN_RST;
			cfg_q.chroma_mode <= 1'b0;
			cfg_q.alpha_on <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_FRAME_WIDTH:  cfg_q.frame_width <= pwdata[12:0];
				REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[12:0];
				REG_GAIN:         cfg_q.gain <= pwdata[7:0];
				REG_CHROMA_MODE:  cfg_q.chroma_mode <= pwdata[0];
				REG_ALPHA_ON:     cfg_q.alpha_on <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (reg_idx)
			REG_FRAME_WIDTH:  prdata = {19'd0, cfg_q.frame_width};
			REG_FRAME_HEIGHT: prdata = {19'd0, cfg_q.frame_height};
			REG_GAIN:         prdata = {24'd0, cfg_q.gain};
			REG_CHROMA_MODE:  prdata = {31'd0, cfg_q.chroma_mode};
			REG_ALPHA_ON:     prdata = {31'd0, cfg_q.alpha_on};
			default:          prdata = 32'd0;
		endcase
	end

	// front: counters, line store, job issue
	pge_front #(.MAX_LINE_WIDTH(MAX_LINE_WIDTH)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.s_tvalid, .s_tready, .s_tdata,
		.q_stat, .push, .push_job
	);

	// job queue
	pge_queue u_queue (
		.clk, .arst_n, .push, .push_job, .pop, .pop_job, .q_stat
	);

	// back: magnitude per job, output register
	pge_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_stat, .pop_job, .pop,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);
endmodule

FILE: sv/pge_front.sv
// front end: accepts pixels, keeps line store and counters, issues 2x2 jobs
// depends on pge_pkg
module pge_front import pge_pkg::*; #(
	parameter int MAX_LINE_WIDTH = LINE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  q_stat_t     q_stat,
	output logic        push,
	output job_t        push_job
);
	localparam int AW = (MAX_LINE_WIDTH > 2) ? $clog2(MAX_LINE_WIDTH) : 1;
	localparam logic [15:0] COL_LIMIT = 16'(MAX_LINE_WIDTH - 1);
	localparam logic [15:0] WID_LIMIT = 16'(MAX_LINE_WIDTH);
	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_READ = 2'd1;
	localparam logic [1:0] F_JOB  = 2'd2;

	logic [1:0]    state_q;
	logic [11:0]   col_cnt_q, row_cnt_q;
	logic [31:0]   prev_q, cur_q, left_q, abl_q, rd_q;
	logic [11:0]   col_q, row_q;
	logic [AW-1:0] addr_q;
	logic          row_end_q;
	logic [3:0]    mask_q;
	logic [31:0]   mem [MAX_LINE_WIDTH];

	logic [15:0] c_eff, w_eff, h_eff, w16, h16;
	logic        row_end, last_row, has_left, has_above, accept;
	logic        we;
	logic [AW-1:0] wa;
	logic [31:0] wd;
	logic [3:0]  mask_nx;

	assign s_tready = (state_q == F_IDLE);
	assign accept = s_tvalid && s_tready;

	always_comb begin
		c_eff = ({4'd0, col_cnt_q} > COL_LIMIT) ? COL_LIMIT : {4'd0, col_cnt_q};
		w16 = {3'd0, cfg.frame_width};
		h16 = {3'd0, cfg.frame_height};
		w_eff = (w16 < 16'd2) ? 16'd2 : ((w16 > WID_LIMIT) ? WID_LIMIT : w16);
		h_eff = (h16 < 16'd2) ? 16'd2 : ((h16 > MAX_FRAME_HEIGHT) ? MAX_FRAME_HEIGHT : h16);
		row_end = (c_eff + 16'd1) >= w_eff;
		last_row = ({4'd0, row_cnt_q} + 16'd1) >= h_eff;
		has_left = (c_eff != 16'd0);
		has_above = (row_cnt_q != 12'd0);
	end

	// pick the lowest pending job
	always_comb begin
		push_job = '0;
		mask_nx = mask_q;
		push = (state_q == F_JOB) && (mask_q != 4'd0) && !q_stat.full;
		priority if (mask_q[0]) begin
			push_job.row = row_q - 12'd1; push_job.col = col_q - 12'd1;
			push_job.p00 = abl_q; push_job.p01 = rd_q; push_job.p10 = left_q; push_job.p11 = cur_q;
			mask_nx[0] = 1'b0;
		end else if (mask_q[1]) begin
			push_job.row = row_q - 12'd1; push_job.col = col_q;
			push_job.p00 = rd_q; push_job.p01 = rd_q; push_job.p10 = cur_q; push_job.p11 = cur_q;
			mask_nx[1] = 1'b0;
		end else if (mask_q[2]) begin
			push_job.row = row_q; push_job.col = col_q - 12'd1;
			push_job.p00 = left_q; push_job.p01 = cur_q; push_job.p10 = left_q; push_job.p11 = cur_q;
			mask_nx[2] = 1'b0;
		end else begin
			push_job.row = row_q; push_job.col = col_q;
			push_job.p00 = cur_q; push_job.p01 = cur_q; push_job.p10 = cur_q; push_job.p11 = cur_q;
			mask_nx[3] = 1'b0;
		end
		push_job.last = (mask_nx == 4'd0);
	end

	// one write port: left pixel while reading, row-end pixel when done
	always_comb begin
		we = 1'b0;
		wa = addr_q;
		wd = cur_q;
		if (state_q == F_READ && col_q != 12'd0) begin
			we = 1'b1;
			wa = addr_q - AW'(1);
			wd = left_q;
		end else if (state_q == F_JOB && mask_q == 4'd0 && row_end_q) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (state_q == F_READ)
			rd_q <= mem[addr_q];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= s_tdata;
			left_q <= prev_q;
			col_q <= c_eff[11:0];
			row_q <= row_cnt_q;
			addr_q <= c_eff[AW-1:0];
			row_end_q <= row_end;
		end
		if (state_q == F_JOB && mask_q == 4'd0)
			abl_q <= rd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			col_cnt_q <= '0;
			row_cnt_q <= '0;
			prev_q <= '0;
			mask_q <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: if (accept) begin
					prev_q <= s_tdata;
					mask_q <= {last_row & row_end, last_row & has_left,
						has_above & row_end, has_above & has_left};
					if (row_end) begin
						col_cnt_q <= '0;
						row_cnt_q <= last_row ? 12'd0 : row_cnt_q + 12'd1;
					end else begin
						col_cnt_q <= c_eff[11:0] + 12'd1;
					end
					state_q <= F_READ;
				end
				F_READ: state_q <= F_JOB;
				F_JOB: begin
					if (mask_q == 4'd0)
						state_q <= F_IDLE;
					else if (push)
						mask_q <= mask_nx;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule

FILE: sv/pge_queue.sv
// short job queue between front and back end
// depends on pge_pkg and the assertion macro header
`include "pixel_gradient_edge_detect_defines.svh"
module pge_queue import pge_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  job_t    push_job,
	input  logic    pop,
	output job_t    pop_job,
	output q_stat_t q_stat
);
	localparam int PW = $clog2(QUEUE_DEPTH);

	job_t          ent_q [QUEUE_DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [PW:0]   count_q;

	assign q_stat.full = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_job = ent_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= wptr_q + PW'(1);
			if (pop)
				rptr_q <= rptr_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	`PGE_ASSERT(a_no_overflow, !(push && q_stat.full), "job pushed into full queue")
	`PGE_ASSERT(a_no_underflow, !(pop && q_stat.empty), "job popped from empty queue")
	`PGE_ASSERT(a_count_range, count_q <= (PW+1)'(QUEUE_DEPTH), "queue count out of range")
	`PGE_ASSERT_NEXT(a_push_fills, push && !pop && !q_stat.full, !q_stat.empty, "push lost")
endmodule

FILE: sv/pge_back.sv
// back end: gradient, squared sum, gain and 8-step square root per job
// depends on pge_pkg
module pge_back import pge_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  q_stat_t     q_stat,
	input  job_t        pop_job,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	output logic        m_tlast
);
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_SQ   = 3'd1;
	localparam logic [2:0] B_MUL  = 3'd2;
	localparam logic [2:0] B_ROOT = 3'd3;
	localparam logic [2:0] B_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [11:0] row_q, col_q;
	logic [7:0]  alpha_q;
	logic        last_q;
	logic [9:0]  vm_q [3];
	logic [9:0]  hm_q [3];
	logic [20:0] ss_q [3];
	logic [15:0] qv_q [3];
	logic        sat_q [3];
	logic [7:0]  root_q [3];
	logic [7:0]  edge_q [3];
	logic [2:0]  step_q;

	function automatic logic signed [11:0] smp(input logic [7:0] b, input logic off);
		logic signed [11:0] s;
		s = $signed({4'd0, b});
		smp = off ? s - 12'sd128 : s;
	endfunction

	logic [9:0]  vm [3];
	logic [9:0]  hm [3];
	logic [28:0] prod [3];
	logic [7:0]  trial [3];
	logic [15:0] tsq [3];
	logic [7:0]  bitv;

	assign pop = (state_q == B_IDLE) && !q_stat.empty;
	assign bitv = 8'd1 << step_q;

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			logic off;
			logic signed [11:0] a, b, c, d, v, h;
			off = (ch > 0) && cfg.chroma_mode;
			a = smp(pop_job.p00[8*ch +: 8], off);
			b = smp(pop_job.p01[8*ch +: 8], off);
			c = smp(pop_job.p10[8*ch +: 8], off);
			d = smp(pop_job.p11[8*ch +: 8], off);
			v = (a - b + c - d) <<< 1;
			h = (c + d - a - b) <<< 1;
			vm[ch] = v[11] ? 10'(-v) : v[9:0];
			hm[ch] = h[11] ? 10'(-h) : h[9:0];
			prod[ch] = 29'(ss_q[ch]) * 29'(cfg.gain);
			trial[ch] = root_q[ch] | bitv;
			tsq[ch] = {8'd0, trial[ch]} * {8'd0, trial[ch]};
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				row_q <= pop_job.row;
				col_q <= pop_job.col;
				last_q <= pop_job.last;
				alpha_q <= cfg.alpha_on ? pop_job.p00[31:24] : 8'd0;
				for (int ch = 0; ch < 3; ch++) begin
					vm_q[ch] <= vm[ch];
					hm_q[ch] <= hm[ch];
				end
			end
			B_SQ: for (int ch = 0; ch < 3; ch++)
				ss_q[ch] <= {11'd0, vm_q[ch]} * {11'd0, vm_q[ch]}
					+ {11'd0, hm_q[ch]} * {11'd0, hm_q[ch]};
			B_MUL: for (int ch = 0; ch < 3; ch++) begin
				qv_q[ch] <= prod[ch][15:0];
				sat_q[ch] <= (prod[ch][28:16] != 13'd0);
				root_q[ch] <= 8'd0;
			end
			B_ROOT: for (int ch = 0; ch < 3; ch++) begin
				logic [7:0] r;
				r = root_q[ch];
				if (tsq[ch] <= qv_q[ch])
					r = trial[ch];
				root_q[ch] <= r;
				if (step_q == 3'd0)
					edge_q[ch] <= (sat_q[ch] ? EDGE_MAX : r)
						^ (((ch > 0) && cfg.chroma_mode) ? CHROMA_BIAS : 8'd0);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: if (pop) state_q <= B_SQ;
				B_SQ: state_q <= B_MUL;
				B_MUL: begin
					step_q <= 3'd7;
					state_q <= B_ROOT;
				end
				B_ROOT: begin
					step_q <= step_q - 3'd1;
					if (step_q == 3'd0)
						state_q <= B_OUT;
				end
				B_OUT: if (m_tready) state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign m_tvalid = (state_q == B_OUT);
	assign m_tlast = last_q;
	assign m_tdata = {alpha_q, edge_q[2], edge_q[1], edge_q[0], col_q, row_q};
endmodule

FILE: sim/tb.sv
// testbench for pixel_gradient_edge_detect: random and directed frames
// checked against a behavioral predictor; depends on pge_pkg and the rtl
`timescale 1ns / 1ps

module tb;
	import pge_pkg::*;

	typedef struct {
		logic [11:0] row;
		logic [11:0] col;
		logic [7:0]  e0;
		logic [7:0]  e1;
		logic [7:0]  e2;
		logic [7:0]  alpha;
		logic        last;
	} edge_px_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // chan_zero, chan_one, chan_two, alpha_in
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;        // out_row, out_col, edge_zero, edge_one, edge_two, alpha_out
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and its copy of the registers
	logic [31:0] line_buf [LINE_WIDTH_DEF];
	logic [31:0] prev_px;
	logic [11:0] col_cnt, row_cnt;
	logic [12:0] cfg_width = WIDTH_RST, cfg_height = HEIGHT_RST;
	logic [7:0]  cfg_gain = GAIN_RST;
	logic        cfg_yuv = 1'b0, cfg_alpha = 1'b0;

	edge_px_t expected_edges[$];
	int   n_errors = 0;
	int   n_pixels = 0;
	int   n_results = 0;
	bit   idle_on = 1'b1;

	pixel_gradient_edge_detect u_top (.*);

	always #5 clk = ~clk;

	// one channel magnitude; chroma bias applied to channels one and two in yuv mode
	function automatic logic [7:0] grad_mag(logic [31:0] p00, p01, p10, p11, int ch);
		int a, b, c, d, v, h;
		longint q;
		int r;
		a = p00[8*ch +: 8];
		b = p01[8*ch +: 8];
		c = p10[8*ch +: 8];
		d = p11[8*ch +: 8];
		if (cfg_yuv && ch > 0) begin
			a -= 128; b -= 128; c -= 128; d -= 128;
		end
		v = 2 * (a - b + c - d);
		h = 2 * (c + d - a - b);
		q = longint'(cfg_gain) * (v * v + h * h);
		r = 0;
		if (q >= 65536) r = 255;
		else
			for (int bit_w = 128; bit_w != 0; bit_w >>= 1)
				if ((r + bit_w) * (r + bit_w) <= q) r += bit_w;
		if (cfg_yuv && ch > 0) r = (r + 128) & 8'hff;
		return r[7:0];
	endfunction

	function automatic void push_edge(logic [11:0] row, col, logic [31:0] p00, p01, p10, p11);
		edge_px_t e;
		e.row = row;
		e.col = col;
		e.e0 = grad_mag(p00, p01, p10, p11, 0);
		e.e1 = grad_mag(p00, p01, p10, p11, 1);
		e.e2 = grad_mag(p00, p01, p10, p11, 2);
		e.alpha = cfg_alpha ? p00[31:24] : 8'd0;
		e.last = 1'b0;
		expected_edges.push_back(e);
	endfunction

	// advance the raster model by one pixel, queuing the edges it completes
	function automatic void predict_pixel(logic [31:0] cur);
		int w, hgt, r, c, n0;
		bit row_end, last_row;
		logic [31:0] above, above_left;
		w = cfg_width < 2 ? 2 : (cfg_width > LINE_WIDTH_DEF ? LINE_WIDTH_DEF : cfg_width);
		hgt = cfg_height < 2 ? 2 : (cfg_height > 4096 ? 4096 : cfg_height);
		r = row_cnt;
		c = col_cnt;
		n0 = expected_edges.size();
		row_end = (c + 1 >= w);
		last_row = (r + 1 >= hgt);
		above = line_buf[c];
		above_left = c >= 1 ? line_buf[c - 1] : 32'd0;
		if (r >= 1) begin
			if (c >= 1) push_edge(r - 1, c - 1, above_left, above, prev_px, cur);
			if (row_end) push_edge(r - 1, c, above, above, cur, cur);
		end
		if (last_row) begin
			if (c >= 1) push_edge(r, c - 1, prev_px, cur, prev_px, cur);
			if (row_end) push_edge(r, c, cur, cur, cur, cur);
		end
		if (expected_edges.size() > n0) expected_edges[$].last = 1'b1;
		if (c >= 1) line_buf[c - 1] = prev_px;
		if (row_end) line_buf[c] = cur;
		prev_px = cur;
		if (row_end) begin
			col_cnt = '0;
			row_cnt = last_row ? 12'd0 : 12'(r + 1);
		end else begin
			col_cnt = 12'(c + 1);
		end
	endfunction

	task automatic idle_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// send one pixel request and predict its edges on acceptance
	task automatic send_pixel(logic [31:0] px);
		idle_gap();
		s_tvalid <= 1'b1;
		s_tdata <= px;
		do @(posedge clk); while (!s_tready);
		predict_pixel(px);
		n_pixels++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_edges.size() != 0) @(posedge clk);
		// the back end may still be busy on a job with no result yet
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_FRAME_WIDTH:  cfg_width = val[12:0];
			REG_FRAME_HEIGHT: cfg_height = val[12:0];
			REG_GAIN:         cfg_gain = val[7:0];
			REG_CHROMA_MODE:  cfg_yuv = val[0];
			REG_ALPHA_ON:     cfg_alpha = val[0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_frame(int w, int h, int g, bit yuv, bit alp);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		write_reg(REG_GAIN, g);
		write_reg(REG_CHROMA_MODE, yuv);
		write_reg(REG_ALPHA_ON, alp);
	endtask

	// directed: extremes, saturation, border replication, yuv bias, alpha
	task automatic test_directed();
		set_frame(2, 2, 255, 1'b0, 1'b1);
		send_pixel(32'h00000000);
		send_pixel(32'hffffffff);
		send_pixel(32'hffffffff);
		send_pixel(32'h00000000);
		wait_drained();
		set_frame(3, 3, 0, 1'b1, 1'b0);
		send_pixel(32'h80808080);
		send_pixel(32'hff00ff00);
		send_pixel(32'h00ff00ff);
		send_pixel(32'h01020304);
		send_pixel(32'h7f7f7f7f);
		send_pixel(32'h80808080);
		send_pixel(32'hfefefefe);
		send_pixel(32'h00000001);
		send_pixel(32'h55aa55aa);
		wait_drained();
		set_frame(4, 2, 1, 1'b1, 1'b1);
		for (int i = 0; i < 8; i++)
			send_pixel({8'($urandom_range(0, 255)), 8'h80, 8'h81, 8'(i * 3)});
		wait_drained();
	endtask

	// random frames; mostly small gains and sizes, smooth pixels mixed in
	task automatic test_random_frames(int n_items);
		int sent;
		int w, h;
		sent = 0;
		while (sent < n_items) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 24) : $urandom_range(2, 6);
			h = $urandom_range(2, 5);
			set_frame(w, h, $urandom_range(0, 3) == 0 ? 8'(255 - $urandom_range(0, 3))
				: $urandom_range(0, 8), $urandom_range(0, 1), $urandom_range(0, 1));
			for (int i = 0; i < w * h; i++) begin
				if ($urandom_range(0, 1)) send_pixel($urandom());
				else send_pixel({4{8'($urandom_range(120, 136))}});
			end
			sent += w * h;
			wait_drained();
		end
	endtask

	// a wider frame once, with idling switched on and off
	task automatic test_wide_frame();
		set_frame(48, 2, 2, 1'b0, 1'b1);
		for (int i = 0; i < 2 * 48; i++) begin
			idle_on = (i % 32) < 16;
			send_pixel($urandom());
		end
		idle_on = 1'b1;
		wait_drained();
	endtask

	// output side: random stalls and in-order compare
	initial begin
		edge_px_t e;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_edges.size() == 0) begin
					$error("unexpected result row %0d col %0d", m_tdata[11:0], m_tdata[23:12]);
					n_errors++;
				end else begin
					e = expected_edges.pop_front();
					if (m_tdata[11:0] !== e.row) begin
						$error("out_row exp %0d got %0d", e.row, m_tdata[11:0]); n_errors++;
					end
					if (m_tdata[23:12] !== e.col) begin
						$error("out_col exp %0d got %0d", e.col, m_tdata[23:12]); n_errors++;
					end
					if (m_tdata[31:24] !== e.e0) begin
						$error("edge_zero exp %0d got %0d", e.e0, m_tdata[31:24]); n_errors++;
					end
					if (m_tdata[39:32] !== e.e1) begin
						$error("edge_one exp %0d got %0d", e.e1, m_tdata[39:32]); n_errors++;
					end
					if (m_tdata[47:40] !== e.e2) begin
						$error("edge_two exp %0d got %0d", e.e2, m_tdata[47:40]); n_errors++;
					end
					if (m_tdata[55:48] !== e.alpha) begin
						$error("alpha_out exp %0d got %0d", e.alpha, m_tdata[55:48]); n_errors++;
					end
					if (m_tlast !== e.last) begin
						$error("last_of_run exp %0d got %0d", e.last, m_tlast); n_errors++;
					end
				end
			end
			if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#40ms;
		$display("tb: errors");
		$finish;
	end

	initial begin
		for (int i = 0; i < LINE_WIDTH_DEF; i++) line_buf[i] = '0;
		prev_px = '0;
		col_cnt = '0;
		row_cnt = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_frames(100);
		test_wide_frame();
		idle_on = 1'b0;
		test_random_frames(30);
		wait_drained();
		$display("covered %0d pixels and %0d edge results over many frame sizes,", n_pixels,
			n_results);
		$display("gains, rgb and yuv modes, alpha on and off, with random stalls");
		if (n_errors == 0) $display("tb: clean");
		else $display("tb: errors");
		$finish;
	end
endmodule
